// ----- rtl/piece_table_edit_engine_macros.svh -----
// Assertion helpers for the piece table edit engine.
// Each macro expects the enclosing module to have aclk and aresetn.
`ifndef PIECE_TABLE_EDIT_ENGINE_MACROS_SVH
`define PIECE_TABLE_EDIT_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pte_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pte_pkg;

    localparam int unsigned MAX_PIECES_DEF   = 64;
    localparam int unsigned ADD_CAPACITY_DEF = 1048576;
    localparam logic [24:0] DOC_LIMIT        = 25'h1000000;

    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_DELETE  = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;
    localparam logic [1:0] REQ_READ    = 2'd3;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_NOOP  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    typedef struct packed {
        logic        from_add;
        logic [23:0] start;
        logic [24:0] length;
    } piece_t;

    // One piece produced by the edit unit for the current sub-step.
    typedef struct packed {
        logic   valid;
        logic   last;
        logic   hit;
        logic   split;
        piece_t piece;
    } emit_t;

endpackage
`default_nettype wire

// ----- rtl/pte_emit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Edit unit: for one old piece and one sub-step, give the piece to append.
module pte_emit (
    input  wire logic              is_insert,
    input  wire logic [1:0]        sub,
    input  wire logic [24:0]       cov,
    input  wire pte_pkg::piece_t   pc,
    input  wire logic [24:0]       pos,
    input  wire logic [24:0]       endp,
    input  wire logic [20:0]       ilen,
    input  wire logic [23:0]       add_start,
    input  wire logic              inserted,
    output pte_pkg::emit_t         em
);

    logic [25:0]     cov_w, end_w, pos_w, endp_w, lcut, rbase;
    logic [24:0]     off;
    logic            hit, keep_l, keep_r;
    pte_pkg::piece_t newp, lpiece, rpiece, ileft, iright;

    always_comb begin
        cov_w  = {1'b0, cov};
        end_w  = cov_w + {1'b0, pc.length};
        pos_w  = {1'b0, pos};
        endp_w = {1'b0, endp};
        off    = pos - cov;
        newp   = '{from_add: 1'b1, start: add_start, length: 25'(ilen)};
        hit    = !inserted && (pos_w < end_w);
        keep_l = cov_w < pos_w;
        keep_r = end_w > endp_w;
        lcut   = (end_w < pos_w) ? end_w : pos_w;
        rbase  = (cov_w > endp_w) ? cov_w : endp_w;
        lpiece = '{from_add: pc.from_add, start: pc.start, length: 25'(lcut - cov_w)};
        rpiece = '{from_add: pc.from_add, start: pc.start + 24'(rbase - cov_w),
                   length: 25'(end_w - rbase)};
        ileft  = '{from_add: pc.from_add, start: pc.start, length: off};
        iright = '{from_add: pc.from_add, start: pc.start + 24'(off),
                   length: pc.length - off};
        em = '0;
        if (is_insert) begin
            if (!hit) begin
                em.valid = 1'b1;
                em.last  = 1'b1;
                em.piece = pc;
            end else if (off == '0) begin
                case (sub)
                    2'd0: begin
                        em.valid = 1'b1;
                        em.piece = newp;
                    end
                    default: begin
                        em.valid = 1'b1;
                        em.last  = 1'b1;
                        em.hit   = 1'b1;
                        em.piece = pc;
                    end
                endcase
            end else begin
                case (sub)
                    2'd0: begin
                        em.valid = 1'b1;
                        em.piece = ileft;
                    end
                    2'd1: begin
                        em.valid = 1'b1;
                        em.piece = newp;
                    end
                    default: begin
                        em.valid = 1'b1;
                        em.last  = 1'b1;
                        em.hit   = 1'b1;
                        em.split = 1'b1;
                        em.piece = iright;
                    end
                endcase
            end
        end else begin
            case (sub)
                2'd0: begin
                    if (keep_l) begin
                        em.valid = 1'b1;
                        em.piece = lpiece;
                        em.last  = !keep_r;
                        em.split = keep_r;
                    end else if (keep_r) begin
                        em.valid = 1'b1;
                        em.piece = rpiece;
                        em.last  = 1'b1;
                    end else begin
                        em.last = 1'b1;
                    end
                end
                default: begin
                    em.valid = 1'b1;
                    em.last  = 1'b1;
                    em.piece = rpiece;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pte_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Merge stage: hold one pending piece, join continuing pieces, write the rest.
module pte_merge #(
    parameter int unsigned MAX_PIECES = pte_pkg::MAX_PIECES_DEF,
    localparam int unsigned CNT_W = $clog2(MAX_PIECES + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             clear,
    input  wire logic             in_valid,
    input  wire pte_pkg::piece_t  in_piece,
    input  wire logic             flush,
    output logic                  wr_en,
    output pte_pkg::piece_t       wr_piece,
    output logic [CNT_W-1:0]      count
);

    pte_pkg::piece_t  pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             joinable;

    always_comb begin
        joinable = pend_valid_reg && (pend_reg.from_add == in_piece.from_add) &&
                   ((26'(pend_reg.start) + 26'(pend_reg.length)) == 26'(in_piece.start));
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        count_next      = count_reg;
        wr_en           = 1'b0;
        wr_piece        = pend_reg;
        if (clear) begin
            pend_valid_next = 1'b0;
            count_next      = '0;
        end else if (in_valid) begin
            if (joinable) begin
                pend_next.length = pend_reg.length + in_piece.length;
            end else begin
                if (pend_valid_reg) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                pend_next       = in_piece;
                pend_valid_next = 1'b1;
            end
        end else if (flush && pend_valid_reg) begin
            wr_en           = 1'b1;
            count_next      = count_reg + CNT_W'(1);
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
        end
        pend_reg <= pend_next;
    end

    assign count = count_reg;

endmodule
`default_nettype wire

// ----- rtl/piece_table_edit_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Piece table edit engine. Requests are insert, delete, restart and read entry,
// one result per request. The table lives in a two-bank memory: an edit scans
// the live bank one entry at a time through a shared edit unit, streams the
// edited and merged pieces into the spare bank, and only swaps banks when the
// edit succeeds, so a rejected edit leaves the table untouched. An insert or
// delete reads every stored piece in turn through the single memory read port
// and emits it, with the new piece put before the piece an insert lands on at
// its start, the new piece between both halves when an insert splits a piece,
// and both kept ends when a delete cuts out the middle of one piece. An edit
// that fails for lack of table room is only known after the full scan and
// takes the same time. Restart, read entry and requests rejected on their
// fields alone skip the scan. s_ready is high only while idle; a result waits
// in the output register until taken, and the next request may be transferred
// meanwhile. cfg_data (original length) may be written at any cycle the block
// is idle; cfg_ready is always high.
`include "piece_table_edit_engine_macros.svh"
module piece_table_edit_engine #(
    parameter int unsigned MAX_PIECES   = pte_pkg::MAX_PIECES_DEF,
    parameter int unsigned ADD_CAPACITY = pte_pkg::ADD_CAPACITY_DEF,
    localparam int unsigned CNT_W = $clog2(MAX_PIECES + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [23:0]       cfg_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_req_type,
    input  wire logic [24:0]       s_position,
    input  wire logic [24:0]       s_end_position,
    input  wire logic [20:0]       s_insert_length,
    input  wire logic [5:0]        s_entry_index,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_status,
    output logic [24:0]            m_document_length,
    output logic [CNT_W-1:0]       m_entry_count,
    output logic [31:0]            m_edit_version,
    output logic                   m_modified,
    output logic                   m_entry_from_add,
    output logic [23:0]            m_entry_start,
    output logic [24:0]            m_entry_length
);

    localparam int unsigned IDX_W  = $clog2(MAX_PIECES);
    localparam int unsigned MEM_AW = IDX_W + 1;
    localparam int unsigned ADD_W  = $clog2(ADD_CAPACITY + 1);
    localparam int unsigned SUM_W  = ((ADD_W > 21) ? ADD_W : 21) + 1;
    localparam int unsigned CMP_W  = (CNT_W > 6) ? CNT_W : 6;
    localparam int unsigned CNT1_W = CNT_W + 1;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b00000001,
        ST_RD     = 8'b00000010,
        ST_EMIT   = 8'b00000100,
        ST_TAIL   = 8'b00001000,
        ST_FLUSH  = 8'b00010000,
        ST_COMMIT = 8'b00100000,
        ST_RWAIT  = 8'b01000000,
        ST_FIN    = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    // Architectural state
    logic [23:0]      orig_reg, orig_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [ADD_W-1:0] add_used_reg, add_used_next;
    logic [31:0]      version_reg, version_next;
    logic             dirty_reg, dirty_next;
    logic [24:0]      doc_reg, doc_next;
    logic             bank_reg, bank_next;

    // Latched request and scan context
    logic             ins_reg, ins_next;
    logic [24:0]      pos_reg, pos_next;
    logic [24:0]      endp_reg, endp_next;
    logic [20:0]      len_reg, len_next;
    logic [CNT_W-1:0] r_reg, r_next;
    logic [24:0]      cov_reg, cov_next;
    logic [1:0]       sub_reg, sub_next;
    logic             inserted_reg, inserted_next;
    logic             split_reg, split_next;

    // Result staging and output register
    logic [1:0]       res_status_reg, res_status_next;
    pte_pkg::piece_t  res_entry_reg, res_entry_next;
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic [24:0]      m_doc_reg, m_doc_next;
    logic [CNT_W-1:0] m_count_reg, m_count_next;
    logic [31:0]      m_ver_reg, m_ver_next;
    logic             m_mod_reg, m_mod_next;
    pte_pkg::piece_t  m_entry_reg, m_entry_next;

    // Memory: two banks of pieces
    pte_pkg::piece_t  mem [2**MEM_AW];
    pte_pkg::piece_t  mem_rdata_reg;
    logic [MEM_AW-1:0] raddr, waddr;
    logic              mem_we;
    pte_pkg::piece_t   mem_wdata;

    // Edit unit and merge stage
    pte_pkg::emit_t    em;
    logic              mg_clear, mg_valid, mg_flush, mg_we;
    pte_pkg::piece_t   mg_in, mg_wr;
    logic [CNT_W-1:0]  mg_count;
    pte_pkg::piece_t   newp;
    logic [1:0]        need;
    logic              s_xfer, restart_wr, fail;

    assign s_xfer    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign newp = '{from_add: 1'b1, start: 24'(add_used_reg), length: 25'(len_reg)};

    pte_emit u_emit (
        .is_insert (ins_reg),
        .sub       (sub_reg),
        .cov       (cov_reg),
        .pc        (mem_rdata_reg),
        .pos       (pos_reg),
        .endp      (endp_reg),
        .ilen      (len_reg),
        .add_start (24'(add_used_reg)),
        .inserted  (inserted_reg),
        .em        (em)
    );

    pte_merge #(.MAX_PIECES(MAX_PIECES)) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (mg_clear),
        .in_valid (mg_valid),
        .in_piece (mg_in),
        .flush    (mg_flush),
        .wr_en    (mg_we),
        .wr_piece (mg_wr),
        .count    (mg_count)
    );

    // Read the requested entry on a read request, otherwise the scan entry.
    always_comb begin
        if (state_reg == ST_IDLE) begin
            raddr = {bank_reg, IDX_W'(s_entry_index)};
        end else begin
            raddr = {bank_reg, r_reg[IDX_W-1:0]};
        end
        restart_wr = s_xfer && (s_req_type == pte_pkg::REQ_RESTART);
        if (restart_wr) begin
            mem_we    = 1'b1;
            waddr     = {bank_reg, IDX_W'(0)};
            mem_wdata = '{from_add: 1'b0, start: 24'd0, length: 25'(orig_reg)};
        end else begin
            mem_we    = mg_we;
            waddr     = {~bank_reg, mg_count[IDX_W-1:0]};
            mem_wdata = mg_wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[raddr];
    end

    always_comb begin
        need = ins_reg ? (split_reg ? 2'd2 : 2'd1) : (split_reg ? 2'd1 : 2'd0);
        fail = (CNT1_W'(total_reg) + CNT1_W'(need)) > CNT1_W'(MAX_PIECES);
    end

    always_comb begin
        state_next      = state_reg;
        orig_next       = orig_reg;
        total_next      = total_reg;
        add_used_next   = add_used_reg;
        version_next    = version_reg;
        dirty_next      = dirty_reg;
        doc_next        = doc_reg;
        bank_next       = bank_reg;
        ins_next        = ins_reg;
        pos_next        = pos_reg;
        endp_next       = endp_reg;
        len_next        = len_reg;
        r_next          = r_reg;
        cov_next        = cov_reg;
        sub_next        = sub_reg;
        inserted_next   = inserted_reg;
        split_next      = split_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_doc_next      = m_doc_reg;
        m_count_next    = m_count_reg;
        m_ver_next      = m_ver_reg;
        m_mod_next      = m_mod_reg;
        m_entry_next    = m_entry_reg;
        mg_clear        = 1'b0;
        mg_valid        = 1'b0;
        mg_flush        = 1'b0;
        mg_in           = em.piece;

        if (cfg_valid && cfg_ready) begin
            orig_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    ins_next       = (s_req_type == pte_pkg::REQ_INSERT);
                    pos_next       = s_position;
                    endp_next      = s_end_position;
                    len_next       = s_insert_length;
                    res_entry_next = '0;
                    r_next         = '0;
                    cov_next       = '0;
                    sub_next       = 2'd0;
                    inserted_next  = 1'b0;
                    split_next     = 1'b0;
                    case (s_req_type)
                        pte_pkg::REQ_INSERT: begin
                            if (s_insert_length == '0) begin
                                res_status_next = pte_pkg::STAT_NOOP;
                                state_next      = ST_FIN;
                            end else if (s_position > doc_reg) begin
                                res_status_next = pte_pkg::STAT_RANGE;
                                state_next      = ST_FIN;
                            end else if ((SUM_W'(add_used_reg) + SUM_W'(s_insert_length)) >
                                         SUM_W'(ADD_CAPACITY) ||
                                         (26'(doc_reg) + 26'(s_insert_length)) >
                                         26'(pte_pkg::DOC_LIMIT)) begin
                                res_status_next = pte_pkg::STAT_FULL;
                                state_next      = ST_FIN;
                            end else begin
                                mg_clear   = 1'b1;
                                state_next = (total_reg == '0) ? ST_TAIL : ST_RD;
                            end
                        end
                        pte_pkg::REQ_DELETE: begin
                            if (s_position >= s_end_position) begin
                                res_status_next = pte_pkg::STAT_NOOP;
                                state_next      = ST_FIN;
                            end else if (s_position > doc_reg || s_end_position > doc_reg) begin
                                res_status_next = pte_pkg::STAT_RANGE;
                                state_next      = ST_FIN;
                            end else begin
                                mg_clear   = 1'b1;
                                state_next = ST_RD;
                            end
                        end
                        pte_pkg::REQ_RESTART: begin
                            total_next      = (orig_reg != '0) ? CNT_W'(1) : '0;
                            doc_next        = 25'(orig_reg);
                            add_used_next   = '0;
                            version_next    = '0;
                            dirty_next      = 1'b0;
                            res_status_next = pte_pkg::STAT_DONE;
                            state_next      = ST_FIN;
                        end
                        default: begin
                            if (CMP_W'(s_entry_index) < CMP_W'(total_reg)) begin
                                state_next = ST_RWAIT;
                            end else begin
                                res_status_next = pte_pkg::STAT_RANGE;
                                state_next      = ST_FIN;
                            end
                        end
                    endcase
                end
            end
            ST_RD: begin
                // wait for the registered read data
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                mg_valid = em.valid;
                if (em.hit) begin
                    inserted_next = 1'b1;
                end
                if (em.split) begin
                    split_next = 1'b1;
                end
                if (em.last) begin
                    r_next   = r_reg + CNT_W'(1);
                    cov_next = cov_reg + mem_rdata_reg.length;
                    sub_next = 2'd0;
                    if ((r_reg + CNT_W'(1)) == total_reg) begin
                        state_next = ins_reg ? ST_TAIL : ST_FLUSH;
                    end else begin
                        state_next = ST_RD;
                    end
                end else begin
                    sub_next = sub_reg + 2'd1;
                end
            end
            ST_TAIL: begin
                // insert at the very end of the document
                mg_in      = newp;
                mg_valid   = !inserted_reg;
                state_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                mg_flush   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (fail) begin
                    res_status_next = pte_pkg::STAT_FULL;
                end else begin
                    res_status_next = pte_pkg::STAT_DONE;
                    bank_next       = ~bank_reg;
                    total_next      = mg_count;
                    version_next    = version_reg + 32'd1;
                    dirty_next      = 1'b1;
                    if (ins_reg) begin
                        add_used_next = ADD_W'(SUM_W'(add_used_reg) + SUM_W'(len_reg));
                        doc_next      = doc_reg + 25'(len_reg);
                    end else begin
                        doc_next = doc_reg - (endp_reg - pos_reg);
                    end
                end
                state_next = ST_FIN;
            end
            ST_RWAIT: begin
                res_status_next = pte_pkg::STAT_DONE;
                res_entry_next  = mem_rdata_reg;
                state_next      = ST_FIN;
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_doc_next    = doc_reg;
                    m_count_next  = total_reg;
                    m_ver_next    = version_reg;
                    m_mod_next    = dirty_reg;
                    m_entry_next  = res_entry_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            orig_reg     <= '0;
            total_reg    <= '0;
            add_used_reg <= '0;
            version_reg  <= '0;
            dirty_reg    <= 1'b0;
            doc_reg      <= '0;
            bank_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            inserted_reg <= 1'b0;
            split_reg    <= 1'b0;
            sub_reg      <= 2'd0;
            r_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            orig_reg     <= orig_next;
            total_reg    <= total_next;
            add_used_reg <= add_used_next;
            version_reg  <= version_next;
            dirty_reg    <= dirty_next;
            doc_reg      <= doc_next;
            bank_reg     <= bank_next;
            m_valid_reg  <= m_valid_next;
            inserted_reg <= inserted_next;
            split_reg    <= split_next;
            sub_reg      <= sub_next;
            r_reg        <= r_next;
        end
        ins_reg        <= ins_next;
        pos_reg        <= pos_next;
        endp_reg       <= endp_next;
        len_reg        <= len_next;
        cov_reg        <= cov_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        m_status_reg   <= m_status_next;
        m_doc_reg      <= m_doc_next;
        m_count_reg    <= m_count_next;
        m_ver_reg      <= m_ver_next;
        m_mod_reg      <= m_mod_next;
        m_entry_reg    <= m_entry_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_document_length = m_doc_reg;
    assign m_entry_count     = m_count_reg;
    assign m_edit_version    = m_ver_reg;
    assign m_modified        = m_mod_reg;
    assign m_entry_from_add  = m_entry_reg.from_add;
    assign m_entry_start     = m_entry_reg.start;
    assign m_entry_length    = m_entry_reg.length;

    `PTE_ASSERT_NOW(a_total_bound, 1'b1, total_reg <= CNT_W'(MAX_PIECES), "piece count over capacity")
    `PTE_ASSERT_NOW(a_add_bound, 1'b1, add_used_reg <= ADD_W'(ADD_CAPACITY), "add buffer overrun")
    `PTE_ASSERT_NOW(a_doc_bound, 1'b1, doc_reg <= pte_pkg::DOC_LIMIT, "document over limit")
    `PTE_ASSERT_NOW(a_merge_wr, mg_we, (state_reg == ST_EMIT) || (state_reg == ST_TAIL) || (state_reg == ST_FLUSH), "merge write outside scan")
    `PTE_ASSERT_NEXT(a_commit_fin, state_reg == ST_COMMIT, state_reg == ST_FIN, "commit not followed by result")

endmodule
`default_nettype wire
